/* sv/upd_pkg.sv */
`timescale 1ns / 1ps
// upd_pkg: shared types, constants and helper functions of the url percent decoder
// depends on nothing; used by every module of the decoder
package upd_pkg;

    localparam logic [7:0] CharSpace   = 8'd32;
    localparam logic [7:0] CharDel     = 8'd127;
    localparam logic [7:0] CharPlus    = 8'd43;
    localparam logic [7:0] CharPercent = 8'd37;
    localparam logic [7:0] CharNul     = 8'd0;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam int MaxBeats = 3;
    localparam int BeatIdxW = $clog2(MaxBeats);
    localparam int BeatCntW = $clog2(MaxBeats + 1);

    // one decoded run: up to three beats, the last one may close the string
    typedef struct packed {
        logic [BeatCntW-1:0]           cnt;
        logic [MaxBeats-1:0][7:0]      bytes;
        logic                          closes;
    } upd_burst_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage

/* sv/url_percent_decoder_top.sv */
`timescale 1ns / 1ps
// url_percent_decoder_top: streaming url percent decoder, front, queue and back joined
// depends on upd_pkg, upd_front, upd_fifo, upd_back
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   input   | in_valid / in_ready  | ch, end_marker
//   output  | out_valid / out_ready| out_byte, byte_valid, string_end, last_of_run
//
// one character beat is taken per cycle while the run queue has room
// the back drives one result beat per cycle while out_ready does not hold it, so runs of two or three beats
// fill the four-entry run queue and stall the input until an entry frees
// a character's first result beat passes through the run queue and then the output register before it is valid
// rst_n clears the escape state, the queue pointers and count, and the output valid flag
module url_percent_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_marker,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       last_of_run
);
    import upd_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    upd_burst_t q_data;
    upd_burst_t q_head;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .end_marker (end_marker),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    upd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_end  (string_end),
        .last_of_run (last_of_run)
    );

endmodule

/* sv/upd_front.sv */
`timescale 1ns / 1ps
// upd_front: accepts characters, tracks the escape state and builds decoded runs
// depends on upd_pkg
module upd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ch,
    input  logic               end_marker,
    input  logic               q_full,
    output logic               q_push,
    output upd_pkg::upd_burst_t q_data
);
    import upd_pkg::*;

    localparam logic [1:0] PhIdle  = 2'd0;
    localparam logic [1:0] PhPct   = 2'd1;
    localparam logic [1:0] PhDigit = 2'd2;

    logic [1:0] escape_phase_reg, escape_phase_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic       accept;

    logic       idle_emit;
    logic [7:0] idle_byte;
    logic       idle_esc;
    logic [7:0] decoded;
    upd_burst_t burst;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // idle-phase decode of the current character
    always_comb
    begin
        idle_emit = 1'b1;
        idle_byte = ch;
        idle_esc  = 1'b0;
        if (ch == CharPlus)
        begin
            idle_byte = CharSpace;
        end
        else if (ch == CharPercent)
        begin
            idle_emit = 1'b0;
            idle_esc  = 1'b1;
        end
    end

    always_comb
    begin
        decoded = {hex_nibble(held_digit_reg), hex_nibble(ch)};
        if (decoded < CharSpace || decoded == CharDel)
        begin
            decoded = CharSpace;
        end
    end

    always_comb
    begin
        burst             = '0;
        escape_phase_next = PhIdle;
        held_digit_next   = held_digit_reg;
        if (end_marker)
        begin
            burst.closes = 1'b1;
            case (escape_phase_reg)
                PhPct:
                begin
                    burst.bytes[0] = CharPercent;
                    burst.bytes[1] = CharNul;
                    burst.cnt      = BeatCntW'(2);
                end
                PhDigit:
                begin
                    burst.bytes[0] = CharPercent;
                    burst.bytes[1] = held_digit_reg;
                    burst.bytes[2] = CharNul;
                    burst.cnt      = BeatCntW'(3);
                end
                default:
                begin
                    burst.bytes[0] = CharNul;
                    burst.cnt      = BeatCntW'(1);
                end
            endcase
        end
        else
        begin
            case (escape_phase_reg)
                PhPct:
                begin
                    if (is_hex(ch))
                    begin
                        held_digit_next   = ch;
                        escape_phase_next = PhDigit;
                    end
                    else if (ch == CharPercent)
                    begin
                        burst.bytes[0] = CharPercent;
                        burst.cnt      = BeatCntW'(1);
                    end
                    else
                    begin
                        burst.bytes[0] = CharPercent;
                        burst.bytes[1] = idle_byte;
                        burst.cnt      = idle_emit ? BeatCntW'(2) : BeatCntW'(1);
                        escape_phase_next = idle_esc ? PhPct : PhIdle;
                    end
                end
                PhDigit:
                begin
                    if (is_hex(ch))
                    begin
                        burst.bytes[0] = decoded;
                        burst.cnt      = BeatCntW'(1);
                    end
                    else
                    begin
                        burst.bytes[0] = CharPercent;
                        burst.bytes[1] = held_digit_reg;
                        burst.bytes[2] = idle_byte;
                        burst.cnt      = idle_emit ? BeatCntW'(3) : BeatCntW'(2);
                        escape_phase_next = idle_esc ? PhPct : PhIdle;
                    end
                end
                default:
                begin
                    burst.bytes[0] = idle_byte;
                    burst.cnt      = idle_emit ? BeatCntW'(1) : BeatCntW'(0);
                    escape_phase_next = idle_esc ? PhPct : PhIdle;
                end
            endcase
        end
    end

    assign q_push = accept && (burst.cnt != '0);
    assign q_data = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_phase_reg <= PhIdle;
            held_digit_reg   <= 8'd0;
        end
        else if (accept)
        begin
            escape_phase_reg <= escape_phase_next;
            held_digit_reg   <= held_digit_next;
        end
    end

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        escape_phase_reg != 2'd3)
        else $error("escape phase reached unused code");
    a_digit_held_hex: assert property (@(posedge clk) disable iff (!rst_n)
        escape_phase_reg == PhDigit |-> is_hex(held_digit_reg))
        else $error("held digit is not hex");
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_marker |-> q_push && burst.closes)
        else $error("terminator produced no closing run");

endmodule

/* sv/upd_fifo.sv */
`timescale 1ns / 1ps
// upd_fifo: short queue of decoded runs between front and back
// depends on upd_pkg
module upd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  upd_pkg::upd_burst_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output upd_pkg::upd_burst_t head
);
    import upd_pkg::*;

    upd_burst_t             mem_reg [FifoDepth];
    logic [FifoPtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FifoCntW-1:0]    count_reg, count_next;

    assign full  = (count_reg == FifoCntW'(FifoDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FifoCntW'(FifoDepth))
        else $error("queue count beyond depth");

endmodule

/* sv/upd_back.sv */
`timescale 1ns / 1ps
// upd_back: walks each queued run and drives result beats through an output register
// depends on upd_pkg
module upd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  upd_pkg::upd_burst_t q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                string_end,
    output logic                last_of_run
);
    import upd_pkg::*;

    logic [BeatIdxW-1:0] idx_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                byte_valid_reg;
    logic                string_end_reg;
    logic                last_reg;
    logic                load;
    logic                is_last;

    assign load    = !q_empty && (!out_valid_reg || out_ready);
    assign is_last = (BeatCntW'(idx_reg) + 1'b1) == q_head.cnt;
    assign q_pop   = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= q_head.bytes[idx_reg];
            byte_valid_reg <= !(is_last && q_head.closes);
            string_end_reg <= is_last && q_head.closes;
            last_reg       <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign string_end  = string_end_reg;
    assign last_of_run = last_reg;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> last_of_run && !byte_valid)
        else $error("closing beat not last or carries data");
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> q_head.cnt != '0)
        else $error("queued run with no beats");
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> BeatCntW'(idx_reg) < q_head.cnt)
        else $error("beat index past end of run");

endmodule

/* tb/url_percent_decoder_top_tb.sv */
`timescale 1ns / 1ps
// url_percent_decoder_top_tb: self-checking bench of the url percent decoder
// depends on upd_pkg and url_percent_decoder_top; predicts every decoded beat and compares
module url_percent_decoder_top_tb;
    import upd_pkg::*;

    typedef enum logic [1:0] {
        EscIdle    = 2'd0,
        EscPercent = 2'd1,
        EscDigit   = 2'd2
    } escape_phase_e;

    typedef struct {
        logic [7:0] ch;
        logic       term;
    } char_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       last_of_run;
    } decoded_beat_t;

    localparam int RandomItems = 330;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] ch          = 8'd0;
    logic       end_marker  = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       last_of_run;

    char_item_t    pending_chars[$];
    decoded_beat_t decoded_beats_due[$];
    decoded_beat_t run_beats[$];
    decoded_beat_t want;
    char_item_t    next_char;

    escape_phase_e esc_phase  = EscIdle;
    logic [7:0]    held_digit = 8'd0;

    int send_idle_pct = 32;
    int recv_idle_pct = 45;
    int chars_taken   = 0;
    int total_chars   = 0;
    int error_count   = 0;

    url_percent_decoder_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_marker  (end_marker),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_end  (string_end),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "A" && c <= "F")
        begin
            return c - "A" + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return c - "a" + 10;
        end
        return -1;
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic v, input logic e);
        decoded_beat_t beat;
        beat.out_byte    = b;
        beat.byte_valid  = v;
        beat.string_end  = e;
        beat.last_of_run = 1'b0;
        run_beats.push_back(beat);
    endfunction

    function automatic void decode_idle(input logic [7:0] c);
        if (c == CharPlus)
        begin
            push_beat(CharSpace, 1'b1, 1'b0);
        end
        else if (c == CharPercent)
        begin
            esc_phase = EscPercent;
        end
        else
        begin
            push_beat(c, 1'b1, 1'b0);
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic term);
        int         lo;
        int         hi;
        logic [7:0] n;
        run_beats.delete();
        if (term)
        begin
            if (esc_phase == EscPercent)
            begin
                push_beat(CharPercent, 1'b1, 1'b0);
            end
            else if (esc_phase == EscDigit)
            begin
                push_beat(CharPercent, 1'b1, 1'b0);
                push_beat(held_digit, 1'b1, 1'b0);
            end
            esc_phase = EscIdle;
            push_beat(CharNul, 1'b0, 1'b1);
        end
        else if (esc_phase == EscPercent)
        begin
            if (hex_value(c) >= 0)
            begin
                held_digit = c;
                esc_phase  = EscDigit;
            end
            else if (c == CharPercent)
            begin
                esc_phase = EscIdle;
                push_beat(CharPercent, 1'b1, 1'b0);
            end
            else
            begin
                esc_phase = EscIdle;
                push_beat(CharPercent, 1'b1, 1'b0);
                decode_idle(c);
            end
        end
        else if (esc_phase == EscDigit)
        begin
            lo        = hex_value(c);
            esc_phase = EscIdle;
            if (lo >= 0)
            begin
                hi = hex_value(held_digit);
                if (hi < 0)
                begin
                    hi = 0;
                end
                n = {hi[3:0], lo[3:0]};
                if (n < CharSpace || n == CharDel)
                begin
                    n = CharSpace;
                end
                push_beat(n, 1'b1, 1'b0);
            end
            else
            begin
                push_beat(CharPercent, 1'b1, 1'b0);
                push_beat(held_digit, 1'b1, 1'b0);
                decode_idle(c);
            end
        end
        else
        begin
            esc_phase = EscIdle;
            decode_idle(c);
        end
        if (run_beats.size() > 0)
        begin
            run_beats[run_beats.size() - 1].last_of_run = 1'b1;
        end
        foreach (run_beats[i])
        begin
            decoded_beats_due.push_back(run_beats[i]);
        end
    endfunction

    task automatic add_char(input logic [7:0] c, input logic term);
        char_item_t item;
        item.ch   = c;
        item.term = term;
        pending_chars.push_back(item);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int unsigned k;
        k = $urandom_range(21);
        if (k < 10)
        begin
            return 8'(k) + "0";
        end
        if (k < 16)
        begin
            return 8'(k - 10) + "A";
        end
        return 8'(k - 16) + "a";
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(255));
        end
        while (hex_value(c) >= 0);
        return c;
    endfunction

    // sender: one beat held until taken, gaps drawn per cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            ch         <= 8'd0;
            end_marker <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_char(ch, end_marker);
                chars_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_char = pending_chars.pop_front();
                    in_valid   <= 1'b1;
                    ch         <= next_char.ch;
                    end_marker <= next_char.term;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, each taken beat checked against the oldest due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                if (decoded_beats_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("unexpected beat: byte %h valid %b end %b last %b",
                                 out_byte, byte_valid, string_end, last_of_run);
                    end
                end
                else
                begin
                    want = decoded_beats_due.pop_front();
                    if (out_byte !== want.out_byte || byte_valid !== want.byte_valid ||
                        string_end !== want.string_end || last_of_run !== want.last_of_run)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch: byte %h/%h valid %b/%b end %b/%b last %b/%b",
                                     want.out_byte, out_byte, want.byte_valid, byte_valid,
                                     want.string_end, string_end,
                                     want.last_of_run, last_of_run);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned pick;

        // directed opening
        add_text("+");
        add_text("%4a");
        add_text("%7F");
        add_text("%%");
        add_text("%+");
        add_text("%4%");
        add_text("G");
        add_text("%a+");
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_text("%");
        add_char(8'hFF, 1'b1);
        add_text("%B");
        add_char(8'h00, 1'b1);
        add_char(8'h5A, 1'b1);

        // random part: random characters, plus signs, well-formed and malformed escapes, and terminators
        while (pending_chars.size() < RandomItems + 26)
        begin
            pick = $urandom_range(15);
            case (pick)
                4:
                begin
                    add_char(CharPlus, 1'b0);
                end
                5, 6, 7, 8, 9:
                begin
                    add_char(CharPercent, 1'b0);
                    add_char(rand_hex_digit(), 1'b0);
                    add_char(rand_hex_digit(), 1'b0);
                end
                10:
                begin
                    add_text("%%");
                end
                11:
                begin
                    add_char(CharPercent, 1'b0);
                    add_char(rand_non_hex(), 1'b0);
                end
                12:
                begin
                    add_char(CharPercent, 1'b0);
                    add_char(rand_hex_digit(), 1'b0);
                    add_char(rand_non_hex(), 1'b0);
                end
                13:
                begin
                    add_char(8'($urandom_range(255)), 1'b1);
                end
                default:
                begin
                    add_char(8'($urandom_range(255)), 1'b0);
                end
            endcase
        end
        add_char(8'h00, 1'b1);
        total_chars = pending_chars.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_taken < total_chars / 3)
        begin
            @(posedge clk);
        end
        send_idle_pct = 45;
        recv_idle_pct = 32;
        while (chars_taken < 2 * total_chars / 3)
        begin
            @(posedge clk);
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (chars_taken < total_chars)
        begin
            @(posedge clk);
        end
        while (decoded_beats_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (error_count == 0 && decoded_beats_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
